// ===== rtl/mnps_pkg.sv =====
// shared types and constants of the mono note priority stack
// used by mnps_cell, mnps_chain and mono_note_priority_stack_core
package mnps_pkg;

    localparam int NOTE_COUNT_DEF = 128;
    localparam int NOTE_W         = 7;
    localparam int VEL_W          = 7;
    localparam int S_DATA_W       = 16;
    localparam int M_DATA_W       = 16;

    // event kind carried on s_tuser
    typedef enum logic {
        OP_NOTE_ON  = 1'b0,
        OP_NOTE_OFF = 1'b1
    } note_op_t;

    // per-cycle commands broadcast to every cell of the chain
    typedef struct packed {
        logic push;     // every cell takes its lower neighbor, cell 0 takes the key
        logic capture;  // mark the occupied cell that holds the key
        logic spread;   // the mark spreads one cell up the chain
        logic shift;    // marked cells take their upper neighbor
    } cell_ctrl_t;

endpackage

// ===== rtl/mnps_cell.sv =====
// one slot of the held-note chain: a note number and a removal mark
// depends on mnps_pkg
module mnps_cell
    import mnps_pkg::*;
#(
    parameter int INDEX   = 0,
    parameter int DEPTH_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cell_ctrl_t        ctrl,
    input  logic [NOTE_W-1:0] key,
    input  logic [DEPTH_W-1:0] depth,
    input  logic [NOTE_W-1:0] below_entry,
    input  logic              below_sel,
    input  logic [NOTE_W-1:0] above_entry,
    output logic [NOTE_W-1:0] entry,
    output logic              sel
);

    logic [NOTE_W-1:0] entry_reg;
    logic [NOTE_W-1:0] entry_next;
    logic              sel_reg;
    logic              sel_next;
    logic              occupied;

    assign occupied = depth > DEPTH_W'(INDEX);

    always_comb begin
        entry_next = entry_reg;
        sel_next   = sel_reg;
        if (ctrl.push) begin
            entry_next = below_entry;
        end
        if (ctrl.capture) begin
            sel_next = occupied && (entry_reg == key);
        end
        if (ctrl.spread) begin
            sel_next = sel_reg | below_sel;
        end
        if (ctrl.shift && sel_reg) begin
            entry_next = above_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg <= 1'b0;
        end else begin
            sel_reg <= sel_next;
        end
    end

    assign entry = entry_reg;
    assign sel   = sel_reg;

endmodule

// ===== rtl/mnps_chain.sv =====
// row of note cells, newest note in cell 0, older notes further up
// depends on mnps_pkg and mnps_cell
module mnps_chain
    import mnps_pkg::*;
#(
    parameter int NOTE_COUNT = NOTE_COUNT_DEF,
    parameter int DEPTH_W    = $clog2(NOTE_COUNT + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cell_ctrl_t         ctrl,
    input  logic [NOTE_W-1:0]  key,
    input  logic [DEPTH_W-1:0] depth,
    output logic [NOTE_W-1:0]  top_entry
);

    logic [NOTE_W-1:0] entries [NOTE_COUNT];
    logic              sels    [NOTE_COUNT];

    for (genvar i = 0; i < NOTE_COUNT; i++) begin : g_cell
        logic [NOTE_W-1:0] below_entry;
        logic              below_sel;
        logic [NOTE_W-1:0] above_entry;

        if (i == 0) begin : g_bottom
            assign below_entry = key;
            assign below_sel   = 1'b0;
        end else begin : g_inner
            assign below_entry = entries[i-1];
            assign below_sel   = sels[i-1];
        end

        // the last cell falls out of the occupied range when it shifts
        if (i == NOTE_COUNT - 1) begin : g_last
            assign above_entry = entries[i];
        end else begin : g_mid
            assign above_entry = entries[i+1];
        end

        mnps_cell #(
            .INDEX   (i),
            .DEPTH_W (DEPTH_W)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .key         (key),
            .depth       (depth),
            .below_entry (below_entry),
            .below_sel   (below_sel),
            .above_entry (above_entry),
            .entry       (entries[i]),
            .sel         (sels[i])
        );
    end

    assign top_entry = entries[0];

endmodule

// ===== rtl/mono_note_priority_stack_core.sv =====
// Last-note-priority voice tracker for a monophonic synth. Each input word is a note
// event (note on or note off, note number, velocity); each produces exactly one result
// word with the sounding note, its valid flag, the gate level and a retrigger pulse flag.
// Held notes live in a chain of NOTE_COUNT cells, newest in cell 0, so the sounding note
// after a release is always read from cell 0. A note-on, an event on a note at or above
// NOTE_COUNT, and a release of a note that is not held go from acceptance straight to the
// result state and back to idle. Releasing a held note passes more states: the matching
// cell is marked, the mark walks one cell per cycle up the chain, the marked cells then
// close the gap, and the new top is taken. A new event is accepted while the previous
// result still waits in the output register; if that register is still full when the
// next result is ready, the result state holds until m_tready frees it. No clearing
// pass is needed after reset.
// depends on mnps_pkg and mnps_chain
module mono_note_priority_stack_core
    import mnps_pkg::*;
#(
    parameter int NOTE_COUNT = NOTE_COUNT_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // event input
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // note[6:0], velocity[13:7], zero fill
    input  logic                s_tuser,   // op: 0 note on, 1 note off
    // result output
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // active_note[6:0], note_valid[7], gate[8],
                                           // retrigger[9], zero fill
);

    localparam int DEPTH_W = $clog2(NOTE_COUNT + 1);
    localparam int IDX_W   = $clog2(NOTE_COUNT);
    localparam int CNT_W   = $clog2(NOTE_COUNT);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_SHIFT  = 3'd2;
    localparam logic [2:0] ST_UPDATE = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;

    // control state
    logic [2:0]            state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DEPTH_W-1:0]    depth_reg, depth_next;
    logic [NOTE_COUNT-1:0] held_reg, held_next;
    logic [NOTE_W-1:0]     sounding_note_reg, sounding_note_next;
    logic                  sounding_valid_reg, sounding_valid_next;
    logic                  gate_reg, gate_next;
    logic                  retrig_reg, retrig_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [NOTE_W-1:0]     key_reg, key_next;

    // input word fields
    logic [NOTE_W-1:0] in_note;
    logic [VEL_W-1:0]  in_vel;
    logic              in_op;
    logic [IDX_W-1:0]  in_idx;
    logic              in_range;
    logic              is_on;
    logic              held_hit;
    logic              accept;

    cell_ctrl_t        ctrl;
    logic [NOTE_W-1:0] chain_key;
    logic [NOTE_W-1:0] top_entry;
    logic [NOTE_W-1:0] out_note;

    assign in_note  = s_tdata[NOTE_W-1:0];
    assign in_vel   = s_tdata[NOTE_W+VEL_W-1:NOTE_W];
    assign in_op    = s_tuser;
    assign in_idx   = in_note[IDX_W-1:0];
    assign in_range = {1'b0, in_note} < (NOTE_W + 1)'(NOTE_COUNT);
    assign is_on    = (in_op == OP_NOTE_ON) && (in_vel != '0);
    assign held_hit = held_reg[in_idx];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // chain commands: push and capture happen in the accept cycle
    always_comb begin
        ctrl.push    = accept && in_range && is_on && !held_hit;
        ctrl.capture = accept && in_range && !is_on && held_hit;
        ctrl.spread  = (state_reg == ST_SCAN);
        ctrl.shift   = (state_reg == ST_SHIFT);
    end

    // the key only matters in the accept cycle; the register keeps it steady afterwards
    assign chain_key = accept ? in_note : key_reg;

    mnps_chain #(
        .NOTE_COUNT (NOTE_COUNT),
        .DEPTH_W    (DEPTH_W)
    ) u_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .key       (chain_key),
        .depth     (depth_reg),
        .top_entry (top_entry)
    );

    assign out_note = sounding_valid_reg ? sounding_note_reg : '0;

    always_comb begin
        state_next          = state_reg;
        cnt_next            = cnt_reg;
        depth_next          = depth_reg;
        held_next           = held_reg;
        sounding_note_next  = sounding_note_reg;
        sounding_valid_next = sounding_valid_reg;
        gate_next           = gate_reg;
        retrig_next         = retrig_reg;
        key_next            = key_reg;
        m_tdata_next        = m_tdata_reg;
        m_tvalid_next       = m_tvalid_reg && !m_tready;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    key_next = in_note;
                    if (in_range && is_on) begin
                        // press: push if new, sound it either way
                        if (!held_hit) begin
                            depth_next        = depth_reg + 1'b1;
                            held_next[in_idx] = 1'b1;
                        end
                        sounding_note_next  = in_note;
                        sounding_valid_next = 1'b1;
                        gate_next           = 1'b1;
                        retrig_next         = 1'b1;
                        state_next          = ST_RESULT;
                    end else if (in_range && held_hit) begin
                        // release of a held note: mark was captured, walk it up
                        held_next[in_idx] = 1'b0;
                        cnt_next          = '0;
                        state_next        = ST_SCAN;
                    end else begin
                        // out of range or release of a note not held
                        retrig_next = 1'b0;
                        state_next  = ST_RESULT;
                    end
                end
            end
            ST_SCAN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NOTE_COUNT - 2)) begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                depth_next = depth_reg - 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (depth_reg != '0) begin
                    sounding_note_next  = top_entry;
                    sounding_valid_next = 1'b1;
                    retrig_next         = !sounding_valid_reg ||
                                          (top_entry != sounding_note_reg);
                end else begin
                    sounding_note_next  = '0;
                    sounding_valid_next = 1'b0;
                    gate_next           = 1'b0;
                    retrig_next         = 1'b0;
                end
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                // wait for the output register to free up
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(M_DATA_W - NOTE_W - 3){1'b0}}, retrig_reg, gate_reg,
                                     sounding_valid_reg, out_note};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            cnt_reg            <= '0;
            depth_reg          <= '0;
            held_reg           <= '0;
            sounding_note_reg  <= '0;
            sounding_valid_reg <= 1'b0;
            gate_reg           <= 1'b0;
            retrig_reg         <= 1'b0;
            m_tvalid_reg       <= 1'b0;
        end else begin
            state_reg          <= state_next;
            cnt_reg            <= cnt_next;
            depth_reg          <= depth_next;
            held_reg           <= held_next;
            sounding_note_reg  <= sounding_note_next;
            sounding_valid_reg <= sounding_valid_next;
            gate_reg           <= gate_next;
            retrig_reg         <= retrig_next;
            m_tvalid_reg       <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        key_reg     <= key_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // the held map and the stack depth always agree between events
    ap_held_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> ($countones(held_reg) == depth_reg))
        else $error("held map count differs from stack depth");

    // a note sounds exactly when the stack is not empty
    ap_sound_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (sounding_valid_reg == (depth_reg != '0)))
        else $error("sounding flag disagrees with stack depth");

    // the gate is open exactly while a note sounds
    ap_gate_sound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (gate_reg == sounding_valid_reg))
        else $error("gate disagrees with sounding flag");

    // a release of a held note is followed by the mark walk
    ap_release_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.capture |=> (state_reg == ST_SCAN))
        else $error("release did not start the chain scan");
`endif

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench for mono_note_priority_stack_core: note events in, voice state out
// a built-in last-note-priority tracker predicts every result word; random bursts and stalls
// depends on mnps_pkg and the core rtl only
`timescale 1ns / 1ps

module tb_top;
    import mnps_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int NOTES        = NOTE_COUNT_DEF;
    localparam int EVENT_TARGET = 2000;   // random events to queue after the directed part
    localparam int IDLE_LIMIT   = 4000;   // cycles with no handshake before giving up
    localparam int HOLD_CYCLES  = 400;    // one long receiver hold-off
    localparam int HOLD_AFTER   = 300;    // events accepted before the hold-off starts

    typedef struct {
        note_op_t   op;
        bit [6:0]   key;
        bit [6:0]   vel;
        bit         drain_first;   // hold this word back until no result is pending
    } note_event_t;

    typedef struct packed {
        bit [6:0]   active_note;
        bit         note_valid;
        bit         gate;
        bit         retrigger;
    } voice_out_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // events waiting for the driver and voice words waiting for the block
    note_event_t event_queue[$];
    voice_out_t  voice_expect[$];

    // tracker state: held keys, press order (oldest first), sounding voice
    bit [NOTES-1:0] key_held;
    bit [6:0]       key_order[NOTES];
    int             key_count;
    bit [6:0]       cur_note;
    bit             cur_valid;
    bit             gate_lvl;

    // handshake bookkeeping shared between clock phases
    bit in_taken;
    int idle_cycles;
    int n_errors;
    int n_events_in;
    int n_results;
    int n_retrig_seen;
    int n_held_releases;
    int n_zero_vel_releases;
    int max_depth;

    // sender burst shaping and receiver stall pattern
    int burst_left;
    int gap_left;
    int rx_mode;
    int rx_mode_left;
    int hold_left;
    bit hold_done;
    int rx_cycle;

    mono_note_priority_stack_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // note[6:0], velocity[13:7], zero fill
        .s_tuser  (s_tuser),    // op: 0 note on, 1 note off
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)     // active_note[6:0], note_valid[7], gate[8], retrigger[9]
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // last-note-priority tracker: updates the held set and returns the voice word
    function automatic voice_out_t track_event(note_op_t op, bit [6:0] key, bit [6:0] vel);
        voice_out_t res;
        bit         retrig;
        bit [6:0]   prev_note;
        bit         prev_valid;
        int         pos;
        int         i;
        retrig = 1'b0;
        if (key < NOTES) begin
            if (op == OP_NOTE_ON && vel != 0) begin
                // press: push only a key not yet held, but always sound it and retrigger
                if (!key_held[key] && key_count < NOTES) begin
                    key_order[key_count] = key;
                    key_count++;
                    key_held[key] = 1'b1;
                end
                cur_note  = key;
                cur_valid = 1'b1;
                gate_lvl  = 1'b1;
                retrig    = 1'b1;
                if (key_count > max_depth)
                    max_depth = key_count;
            end else if (key_held[key]) begin
                // release of a held key, explicit or by zero velocity
                n_held_releases++;
                if (op == OP_NOTE_ON)
                    n_zero_vel_releases++;
                key_held[key] = 1'b0;
                prev_note  = cur_note;
                prev_valid = cur_valid;
                pos = key_count;
                for (i = 0; i < key_count; i++) begin
                    if (key_order[i] == key && pos == key_count)
                        pos = i;
                end
                // close the gap left by the released key
                for (i = pos; i + 1 < key_count; i++)
                    key_order[i] = key_order[i + 1];
                if (pos < key_count)
                    key_count--;
                if (key_count > 0) begin
                    // newest remaining key sounds, retrigger only on a change
                    cur_note  = key_order[key_count - 1];
                    cur_valid = 1'b1;
                    retrig    = !prev_valid || cur_note != prev_note;
                end else begin
                    cur_note  = '0;
                    cur_valid = 1'b0;
                    gate_lvl  = 1'b0;
                end
            end
            // release of a key that is not held leaves everything as it is
        end
        res.active_note = cur_valid ? cur_note : 7'd0;
        res.note_valid  = cur_valid;
        res.gate        = gate_lvl;
        res.retrigger   = retrig;
        return res;
    endfunction

    task automatic queue_event(note_op_t op, bit [6:0] key, bit [6:0] vel);
        note_event_t ev;
        ev.op          = op;
        ev.key         = key;
        ev.vel         = vel;
        ev.drain_first = 1'b0;
        event_queue.push_back(ev);
    endtask

    // release one key: either an explicit note off (velocity is don't-care) or
    // a note on with zero velocity
    task automatic queue_release(bit [6:0] key);
        if ($urandom_range(0, 2) == 0)
            queue_event(OP_NOTE_ON, key, 7'd0);
        else
            queue_event(OP_NOTE_OFF, key, 7'($urandom_range(0, 127)));
    endtask

    task automatic shuffle_keys(ref bit [6:0] keys[$]);
        int       i;
        int       j;
        bit [6:0] t;
        for (i = keys.size() - 1; i > 0; i--) begin
            j       = $urandom_range(0, i);
            t       = keys[i];
            keys[i] = keys[j];
            keys[j] = t;
        end
    endtask

    // a chord: press a few keys (sometimes re-pressing one), then let them go
    // in a random order, now and then leaving one held for later events
    task automatic queue_chord();
        bit [6:0] keys[$];
        bit [6:0] k;
        int       n;
        int       i;
        n = $urandom_range(1, 10);
        for (i = 0; i < n; i++) begin
            k = 7'($urandom_range(0, 127));
            keys.push_back(k);
            queue_event(OP_NOTE_ON, k, 7'($urandom_range(1, 127)));
            if ($urandom_range(0, 7) == 0)
                queue_event(OP_NOTE_ON, keys[$urandom_range(0, keys.size() - 1)],
                            7'($urandom_range(1, 127)));
        end
        shuffle_keys(keys);
        foreach (keys[i]) begin
            if ($urandom_range(0, 9) != 0)
                queue_release(keys[i]);
        end
    endtask

    // stimulus: directed events first, then chords, noise and one full-keyboard sweep
    initial begin : stim
        bit [6:0] sweep_keys[$];
        int       mark;
        bit       swept;
        int       i;
        int       stop_at;

        // release on an empty stack, velocity ignored on note off
        queue_event(OP_NOTE_OFF, 7'd0, 7'd127);
        // extremes of note and velocity
        queue_event(OP_NOTE_ON, 7'd127, 7'd127);
        queue_event(OP_NOTE_ON, 7'd0, 7'd1);
        // re-press of a held key that is not on top
        queue_event(OP_NOTE_ON, 7'd127, 7'd64);
        // release of a key that is not held
        queue_event(OP_NOTE_OFF, 7'd64, 7'd0);
        // zero-velocity note on releases the sounding key
        queue_event(OP_NOTE_ON, 7'd127, 7'd0);
        // last key released: stack empties, gate closes
        queue_event(OP_NOTE_OFF, 7'd0, 7'd127);
        // zero-velocity note on with nothing held
        queue_event(OP_NOTE_ON, 7'd33, 7'd0);
        // zero-velocity release empties the stack and must close the gate
        queue_event(OP_NOTE_ON, 7'd5, 7'd85);
        queue_event(OP_NOTE_ON, 7'd6, 7'd42);
        queue_event(OP_NOTE_ON, 7'd6, 7'd0);
        queue_event(OP_NOTE_ON, 7'd5, 7'd0);
        // releasing a key below the top keeps the voice, no retrigger
        queue_event(OP_NOTE_ON, 7'd10, 7'd100);
        queue_event(OP_NOTE_ON, 7'd20, 7'd100);
        queue_event(OP_NOTE_ON, 7'd30, 7'd100);
        queue_event(OP_NOTE_OFF, 7'd20, 7'd0);
        queue_event(OP_NOTE_OFF, 7'd30, 7'd55);
        queue_event(OP_NOTE_OFF, 7'd10, 7'd127);
        // re-press moves the voice but not the order; its release falls back
        queue_event(OP_NOTE_ON, 7'd1, 7'd1);
        queue_event(OP_NOTE_ON, 7'd2, 7'd127);
        queue_event(OP_NOTE_ON, 7'd1, 7'd127);
        queue_event(OP_NOTE_OFF, 7'd1, 7'd0);
        queue_event(OP_NOTE_OFF, 7'd2, 7'd0);

        // first random word waits until the directed part has fully drained
        mark = event_queue.size();
        stop_at = mark + EVENT_TARGET;
        swept = 1'b0;
        while (event_queue.size() < stop_at) begin
            if (!swept && event_queue.size() >= mark + EVENT_TARGET / 2) begin
                // whole keyboard pressed in random order, then released the same way
                event_queue[event_queue.size() - 1].drain_first = 1'b1;
                for (i = 0; i < NOTES; i++)
                    sweep_keys.push_back(7'(i));
                shuffle_keys(sweep_keys);
                foreach (sweep_keys[i])
                    queue_event(OP_NOTE_ON, sweep_keys[i], 7'($urandom_range(1, 127)));
                shuffle_keys(sweep_keys);
                foreach (sweep_keys[i])
                    queue_release(sweep_keys[i]);
                swept = 1'b1;
            end else if ($urandom_range(0, 9) < 7) begin
                queue_chord();
            end else begin
                // noise: any op, any key, any velocity, zero velocity favored
                repeat ($urandom_range(1, 10))
                    queue_event(note_op_t'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                                ($urandom_range(0, 3) == 0) ? 7'd0 : 7'($urandom_range(0, 127)));
            end
        end
        event_queue[mark].drain_first = 1'b1;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // wait for every word to be taken and every result to come back
        while (event_queue.size() != 0 || s_tvalid || voice_expect.size() != 0)
            @(posedge aclk);
        // a release can still be walking the chain, let any stray word show up
        repeat (NOTES + 16) @(posedge aclk);

        $display("covered %0d note events, %0d voice words checked, %0d retriggers",
                 n_events_in, n_results, n_retrig_seen);
        $display("held releases %0d (%0d by zero velocity), deepest stack %0d of %0d keys",
                 n_held_releases, n_zero_vel_releases, max_depth, NOTES);
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // driver: next word goes out at the falling edge once the current one is taken
    always @(negedge aclk) begin : drv
        note_event_t ev;
        logic        offer;
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= 1'b0;
            burst_left = $urandom_range(1, 48);
            gap_left   = 0;
        end else if (!s_tvalid || in_taken) begin
            offer = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (event_queue.size() != 0 &&
                         !(event_queue[0].drain_first && voice_expect.size() != 0)) begin
                ev    = event_queue.pop_front();
                offer = 1'b1;
                s_tdata <= {{(S_DATA_W - 2 * 7){1'b0}}, ev.vel, ev.key};
                s_tuser <= ev.op;
                // end of a burst: pick the next burst length and the gap before it
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
                end else begin
                    burst_left--;
                end
            end
            s_tvalid <= offer;
        end
    end

    // receiver: stall mode changes every so often, plus one long hold-off
    always @(negedge aclk) begin : rcv
        logic rdy;
        if (!aresetn) begin
            m_tready     <= 1'b0;
            rx_mode      = 0;
            rx_mode_left = 0;
            hold_left    = 0;
            hold_done    = 1'b0;
            rx_cycle     = 0;
        end else begin
            rx_cycle++;
            if (!hold_done && n_events_in >= HOLD_AFTER) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(16, 200);
            end else begin
                rx_mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                case (rx_mode)
                    0:       rdy = 1'b1;                          // always ready
                    1:       rdy = 1'($urandom_range(0, 1));      // coin flip
                    2:       rdy = ($urandom_range(0, 7) == 0);   // mostly stalled
                    default: rdy = (rx_cycle % 5) != 0;           // periodic hiccup
                endcase
            end
            m_tready <= rdy;
        end
    end

    // monitor: results checked before new predictions are queued, then the watchdog
    always @(posedge aclk) begin : mon
        voice_out_t got;
        voice_out_t want;
        if (!aresetn) begin
            in_taken    = 1'b0;
            idle_cycles = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.active_note = m_tdata[6:0];
                got.note_valid  = m_tdata[7];
                got.gate        = m_tdata[8];
                got.retrigger   = m_tdata[9];
                n_results++;
                if (got.retrigger)
                    n_retrig_seen++;
                if (voice_expect.size() == 0) begin
                    $error("voice word 0x%0h with no event pending", m_tdata);
                    n_errors++;
                end else begin
                    want = voice_expect.pop_front();
                    if (got.active_note != want.active_note) begin
                        $error("active_note: expected %0d, got %0d",
                               want.active_note, got.active_note);
                        n_errors++;
                    end
                    if (got.note_valid != want.note_valid) begin
                        $error("note_valid: expected %0d, got %0d",
                               want.note_valid, got.note_valid);
                        n_errors++;
                    end
                    if (got.gate != want.gate) begin
                        $error("gate: expected %0d, got %0d", want.gate, got.gate);
                        n_errors++;
                    end
                    if (got.retrigger != want.retrigger) begin
                        $error("retrigger: expected %0d, got %0d",
                               want.retrigger, got.retrigger);
                        n_errors++;
                    end
                end
            end

            // predict from the word the block just took
            in_taken = s_tvalid && s_tready;
            if (in_taken) begin
                voice_expect.push_back(track_event(note_op_t'(s_tuser), s_tdata[6:0],
                                                   s_tdata[13:7]));
                n_events_in++;
            end

            if (in_taken || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $error("no handshake for %0d cycles, %0d results outstanding",
                           IDLE_LIMIT, voice_expect.size());
                    $display("CHECKS FAILED");
                    $finish;
                end
            end
        end
    end

endmodule

// ===== mono_note_priority_stack_core.f =====
rtl/mnps_pkg.sv
rtl/mnps_cell.sv
rtl/mnps_chain.sv
rtl/mono_note_priority_stack_core.sv
dv/tb_top.sv
